>>> design/vtv_pkg.sv
package vtv_pkg;

   typedef struct packed {
      logic              kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] pos_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic              w_zero;
      logic              saturated;
   } rsp_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int SCREEN_WIDTH    = 13;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW0   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW1   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW2   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW3   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HEIGHT = 3'd5;

   localparam logic [63:0] ROW0_RESET = 64'h0000_0000_0000_0100;
   localparam logic [63:0] ROW1_RESET = 64'h0000_0000_0100_0000;
   localparam logic [63:0] ROW2_RESET = 64'h0000_0100_0000_0000;
   localparam logic [63:0] ROW3_RESET = 64'h0100_0000_0000_0000;
   localparam logic [SCREEN_WIDTH-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SCREEN_WIDTH-1:0] HEIGHT_RESET = 13'd480;

   // 1.0 in Q16.16
   localparam int ONE_Q16 = 65536;

endpackage

>>> design/vtv_div.sv
module vtv_div #(
   parameter int NW = 62,
   parameter int DW = 33,
   parameter int QW = 32
) (
   input  logic                 clock,
   input  logic [NW-1:0]        n_mag,
   input  logic [DW-1:0]        d_mag,
   input  logic                 neg,
   output logic signed [QW-1:0] quot,
   output logic                 sat
);

   localparam int UW   = NW - QW;
   localparam int CMPW = (UW > DW) ? UW : DW;
   localparam logic [QW-1:0] HALF = {1'b1, {(QW-1){1'b0}}};
   localparam logic signed [QW-1:0] HI = {1'b0, {(QW-1){1'b1}}};
   localparam logic signed [QW-1:0] LO = {1'b1, {(QW-1){1'b0}}};

   logic [DW-1:0] r_ff   [0:QW];
   logic [QW-1:0] nl_ff  [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic [DW-1:0] d_ff   [0:QW];
   logic          ovf_ff [0:QW];
   logic          neg_ff [0:QW];

   logic [CMPW-1:0] upper;
   logic [CMPW-1:0] dext;
   logic [DW:0]     trial  [1:QW];
   logic            ge     [1:QW];
   logic signed [QW-1:0] quot_in;
   logic            sat_in;
   logic signed [QW-1:0] quot_ff;
   logic            sat_ff;

   assign upper = CMPW'(n_mag[NW-1:QW]);
   assign dext  = CMPW'(d_mag);

   always_comb begin
      for (int k = 1; k <= QW; k++) begin
         trial[k] = {r_ff[k-1], nl_ff[k-1][QW-1]};
         ge[k]    = trial[k] >= {1'b0, d_ff[k-1]};
      end
   end

   // quotient is only known to fit when the top part is below the divisor
   always_ff @(posedge clock) begin
      r_ff[0]   <= DW'(upper);
      nl_ff[0]  <= n_mag[QW-1:0];
      q_ff[0]   <= '0;
      d_ff[0]   <= d_mag;
      ovf_ff[0] <= upper >= dext;
      neg_ff[0] <= neg;
      for (int k = 1; k <= QW; k++) begin
         r_ff[k]   <= ge[k] ? DW'(trial[k] - {1'b0, d_ff[k-1]}) : DW'(trial[k]);
         nl_ff[k]  <= {nl_ff[k-1][QW-2:0], 1'b0};
         q_ff[k]   <= {q_ff[k-1][QW-2:0], ge[k]};
         d_ff[k]   <= d_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   always_comb begin
      if (neg_ff[QW]) begin
         sat_in  = ovf_ff[QW] || (q_ff[QW] > HALF);
         quot_in = sat_in ? LO : QW'(-q_ff[QW]);
      end else begin
         sat_in  = ovf_ff[QW] || q_ff[QW][QW-1];
         quot_in = sat_in ? HI : QW'(q_ff[QW]);
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      sat_ff  <= sat_in;
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;

endmodule

>>> design/vertex_transform_viewport.sv
// Vertex transform, perspective divide and viewport mapping.
// Input: a vertex word is taken on req_data at each clock edge where start is
// high and busy is low. busy is always low: one vertex per cycle is accepted.
// Output: each vertex yields one result word on rsp_data, marked by a
// one-cycle rsp_valid strobe. The receiver cannot stall, so results are
// never held back and nothing upstream waits on the output side.
// Delay from accept to strobe is the same in clip and screen mode; it is
// set by the three divide pipelines, which retire one quotient bit per
// stage.
// Throughput: one vertex per clock, results in accept order.
// Config: csr_we writes csr_wdata into register csr_index (rows 0..3 of the
// Q8.8 matrix, then viewport width and height). Write only while no vertex
// is in flight.
// Reset: synchronous, active high; flushes all in-flight vertices and loads
// the identity matrix and a 640x480 viewport.
module vertex_transform_viewport #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  vtv_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   output vtv_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [vtv_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [vtv_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   import vtv_pkg::*;

   localparam int CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
   localparam int PW = CW + 16;          // entry times coordinate
   localparam int SW = CW + 18;          // row sum
   localparam int XW = CW + 14;          // |cx+cw| times width
   localparam int NXW = XW + 16;
   localparam int NZW = CW + 16;
   localparam int DW = CW + 1;
   localparam int DEPTH = CW + 4;        // side pipe from clip regs to divider out
   localparam int LAT = CW + 7;
   localparam logic signed [CW-1:0] HI = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] LO = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] ONE_SAT = (CW > 17) ? CW'(ONE_Q16) : HI;
   localparam logic ONE_CLAMP = (CW > 17) ? 1'b0 : 1'b1;

   // configuration
   logic [63:0]             mrow_ff [4];
   logic [SCREEN_WIDTH-1:0] scr_w_ff;
   logic [SCREEN_WIDTH-1:0] scr_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mrow_ff[0] <= ROW0_RESET;
         mrow_ff[1] <= ROW1_RESET;
         mrow_ff[2] <= ROW2_RESET;
         mrow_ff[3] <= ROW3_RESET;
         scr_w_ff   <= WIDTH_RESET;
         scr_h_ff   <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROW0:   mrow_ff[0] <= csr_wdata;
            REG_ROW1:   mrow_ff[1] <= csr_wdata;
            REG_ROW2:   mrow_ff[2] <= csr_wdata;
            REG_ROW3:   mrow_ff[3] <= csr_wdata;
            REG_WIDTH:  scr_w_ff   <= csr_wdata[SCREEN_WIDTH-1:0];
            REG_HEIGHT: scr_h_ff   <= csr_wdata[SCREEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: sixteen products
   logic signed [CW-1:0] p_in [4];
   logic signed [PW-1:0] prod_in [4][4];
   logic signed [PW-1:0] prod_ff [4][4];
   logic                 v1_ff;
   logic                 kind1_ff;

   always_comb begin
      p_in[0] = req_data.pos_x[CW-1:0];
      p_in[1] = req_data.pos_y[CW-1:0];
      p_in[2] = req_data.pos_z[CW-1:0];
      p_in[3] = req_data.pos_w[CW-1:0];
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 4; k++) begin
            prod_in[r][k] = PW'($signed(mrow_ff[r][16*k +: 16])) * PW'(p_in[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      kind1_ff <= req_data.kind;
      prod_ff  <= prod_in;
   end

   // stage 2: row sums, round half up to Q16.16, clamp
   logic signed [SW-1:0] acc_in [4];
   logic [10:0]          top_bits [4];
   logic signed [CW-1:0] c_in [4];
   logic                 csat_in;
   logic signed [CW-1:0] c_ff [4];
   logic                 csat_ff;
   logic                 v2_ff;
   logic                 kind2_ff;

   always_comb begin
      csat_in = 1'b0;
      for (int r = 0; r < 4; r++) begin
         acc_in[r] = SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2])
                   + SW'(prod_ff[r][3]) + SW'(128);
         top_bits[r] = acc_in[r][SW-1:CW+7];
         if ((&top_bits[r]) || !(|top_bits[r])) begin
            c_in[r] = acc_in[r][CW+7:8];
         end else begin
            c_in[r] = acc_in[r][SW-1] ? LO : HI;
            csat_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      kind2_ff <= kind1_ff;
      c_ff     <= c_in;
      csat_ff  <= csat_in;
   end

   // stage 3: numerator sums, magnitudes and quotient signs
   logic signed [CW:0] sx_in;
   logic signed [CW:0] sy_in;
   logic [CW:0]        ax_ff;
   logic [CW:0]        ay_ff;
   logic [CW-1:0]      az_ff;
   logic [CW-1:0]      aw_ff;
   logic               negx_ff;
   logic               negy_ff;
   logic               negz_ff;

   assign sx_in = (CW+1)'(c_ff[0]) + (CW+1)'(c_ff[3]);
   assign sy_in = (CW+1)'(c_ff[3]) - (CW+1)'(c_ff[1]);

   always_ff @(posedge clock) begin
      ax_ff   <= sx_in[CW] ? (CW+1)'(-sx_in) : (CW+1)'(sx_in);
      ay_ff   <= sy_in[CW] ? (CW+1)'(-sy_in) : (CW+1)'(sy_in);
      az_ff   <= c_ff[2][CW-1] ? CW'(-c_ff[2]) : CW'(c_ff[2]);
      aw_ff   <= c_ff[3][CW-1] ? CW'(-c_ff[3]) : CW'(c_ff[3]);
      negx_ff <= sx_in[CW] ^ c_ff[3][CW-1];
      negy_ff <= sy_in[CW] ^ c_ff[3][CW-1];
      negz_ff <= c_ff[2][CW-1] ^ c_ff[3][CW-1];
   end

   // stage 4: scale by viewport size
   logic [XW-1:0] px_ff;
   logic [XW-1:0] py_ff;
   logic [CW-1:0] az4_ff;
   logic [CW-1:0] aw4_ff;
   logic          negx4_ff;
   logic          negy4_ff;
   logic          negz4_ff;

   always_ff @(posedge clock) begin
      px_ff    <= XW'(ax_ff) * XW'(scr_w_ff);
      py_ff    <= XW'(ay_ff) * XW'(scr_h_ff);
      az4_ff   <= az_ff;
      aw4_ff   <= aw_ff;
      negx4_ff <= negx_ff;
      negy4_ff <= negy_ff;
      negz4_ff <= negz_ff;
   end

   // divide pipelines
   logic signed [CW-1:0] qx, qy, qz;
   logic                 sx_sat, sy_sat, sz_sat;

   vtv_div #(.NW(NXW), .DW(DW), .QW(CW)) u_div_x (
      .clock (clock),
      .n_mag ({px_ff, 16'd0}),
      .d_mag ({aw4_ff, 1'b0}),
      .neg   (negx4_ff),
      .quot  (qx),
      .sat   (sx_sat)
   );

   vtv_div #(.NW(NXW), .DW(DW), .QW(CW)) u_div_y (
      .clock (clock),
      .n_mag ({py_ff, 16'd0}),
      .d_mag ({aw4_ff, 1'b0}),
      .neg   (negy4_ff),
      .quot  (qy),
      .sat   (sy_sat)
   );

   vtv_div #(.NW(NZW), .DW(DW), .QW(CW)) u_div_z (
      .clock (clock),
      .n_mag ({az4_ff, 16'd0}),
      .d_mag ({1'b0, aw4_ff}),
      .neg   (negz4_ff),
      .quot  (qz),
      .sat   (sz_sat)
   );

   // side pipe: clip results travel alongside the dividers
   logic                 sv_ff    [DEPTH];
   logic                 skind_ff [DEPTH];
   logic                 ssat_ff  [DEPTH];
   logic signed [CW-1:0] sc_ff    [DEPTH][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < DEPTH; d++) begin
            sv_ff[d] <= 1'b0;
         end
      end else begin
         sv_ff[0] <= v2_ff;
         for (int d = 1; d < DEPTH; d++) begin
            sv_ff[d] <= sv_ff[d-1];
         end
      end
      skind_ff[0] <= kind2_ff;
      ssat_ff[0]  <= csat_ff;
      sc_ff[0]    <= c_ff;
      for (int d = 1; d < DEPTH; d++) begin
         skind_ff[d] <= skind_ff[d-1];
         ssat_ff[d]  <= ssat_ff[d-1];
         sc_ff[d]    <= sc_ff[d-1];
      end
   end

   // output word
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in = '0;
      priority if (!skind_ff[DEPTH-1]) begin
         rsp_in.out_x     = 32'(sc_ff[DEPTH-1][0]);
         rsp_in.out_y     = 32'(sc_ff[DEPTH-1][1]);
         rsp_in.out_z     = 32'(sc_ff[DEPTH-1][2]);
         rsp_in.out_w     = 32'(sc_ff[DEPTH-1][3]);
         rsp_in.saturated = ssat_ff[DEPTH-1];
      end else if (sc_ff[DEPTH-1][3] == '0) begin
         rsp_in.w_zero = 1'b1;
      end else begin
         rsp_in.out_x     = 32'(qx);
         rsp_in.out_y     = 32'(qy);
         rsp_in.out_z     = 32'(qz);
         rsp_in.out_w     = 32'(ONE_SAT);
         rsp_in.saturated = ssat_ff[DEPTH-1] || sx_sat || sy_sat || sz_sat || ONE_CLAMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sv_ff[DEPTH-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("accepted word not delivered after fixed latency");

   a_wzero_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.w_zero |-> !rsp_data.saturated)
      else $error("w_zero word flagged as saturated");

   a_wzero_zeros: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.w_zero |->
         rsp_data.out_x == 32'sd0 && rsp_data.out_y == 32'sd0 &&
         rsp_data.out_z == 32'sd0 && rsp_data.out_w == 32'sd0)
      else $error("w_zero word carries nonzero coordinates");

endmodule

>>> tb/sv/vertex_transform_viewport_checker.sv
`timescale 1ns / 1ps

module vertex_transform_viewport_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  vtv_pkg::req_type                    req_data,
   input  logic                                rsp_valid,
   input  vtv_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [vtv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [vtv_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                  pending,
   output int                                  failures
);
   import vtv_pkg::*;

   logic [63:0]             matrix_rows [4];
   logic [SCREEN_WIDTH-1:0] view_w;
   logic [SCREEN_WIDTH-1:0] view_h;
   rsp_type                 expected_vertices [$];

   function automatic longint clamp_q16(longint v, ref bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic rsp_type transform_vertex(req_type v);
      longint pos [4];
      longint clip [4];
      longint acc, den, wv, hv;
      logic signed [15:0] entry;
      bit sat;
      rsp_type r;
      sat = 1'b0;
      pos[0] = longint'(v.pos_x);
      pos[1] = longint'(v.pos_y);
      pos[2] = longint'(v.pos_z);
      pos[3] = longint'(v.pos_w);
      for (int row = 0; row < 4; row++) begin
         acc = 0;
         for (int k = 0; k < 4; k++) begin
            entry = matrix_rows[row][16*k +: 16];
            acc += longint'(entry) * pos[k];
         end
         // Q.24 sum, round half up to Q16.16
         clip[row] = clamp_q16((acc + 128) >>> 8, sat);
      end
      r.w_zero = 1'b0;
      if (!v.kind) begin
         r.out_x = 32'(clip[0]);
         r.out_y = 32'(clip[1]);
         r.out_z = 32'(clip[2]);
         r.out_w = 32'(clip[3]);
      end else if (clip[3] == 0) begin
         r = '0;
         r.w_zero = 1'b1;
         sat = 1'b0;
      end else begin
         wv = longint'(view_w);
         hv = longint'(view_h);
         den = 2 * clip[3];
         r.out_x = 32'(clamp_q16(((clip[0] + clip[3]) * wv * ONE_Q16) / den, sat));
         r.out_y = 32'(clamp_q16(((clip[3] - clip[1]) * hv * ONE_Q16) / den, sat));
         r.out_z = 32'(clamp_q16((clip[2] * ONE_Q16) / clip[3], sat));
         r.out_w = ONE_Q16;
      end
      r.saturated = sat;
      return r;
   endfunction

   assign pending = expected_vertices.size();

   always @(posedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         matrix_rows[0] <= ROW0_RESET;
         matrix_rows[1] <= ROW1_RESET;
         matrix_rows[2] <= ROW2_RESET;
         matrix_rows[3] <= ROW3_RESET;
         view_w <= WIDTH_RESET;
         view_h <= HEIGHT_RESET;
         failures <= 0;
         expected_vertices.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ROW0:   matrix_rows[0] <= csr_wdata;
               REG_ROW1:   matrix_rows[1] <= csr_wdata;
               REG_ROW2:   matrix_rows[2] <= csr_wdata;
               REG_ROW3:   matrix_rows[3] <= csr_wdata;
               REG_WIDTH:  view_w <= csr_wdata[SCREEN_WIDTH-1:0];
               REG_HEIGHT: view_h <= csr_wdata[SCREEN_WIDTH-1:0];
               default: ;
            endcase
         end
         if (start && !busy)
            expected_vertices.push_back(transform_vertex(req_data));
         if (rsp_valid) begin
            if (expected_vertices.size() == 0) begin
               $error("unexpected result word");
               failures <= failures + 1;
            end else begin
               exp_word = expected_vertices.pop_front();
               if (rsp_data.out_x !== exp_word.out_x)
                  $error("out_x: expected %0d, got %0d", exp_word.out_x, rsp_data.out_x);
               if (rsp_data.out_y !== exp_word.out_y)
                  $error("out_y: expected %0d, got %0d", exp_word.out_y, rsp_data.out_y);
               if (rsp_data.out_z !== exp_word.out_z)
                  $error("out_z: expected %0d, got %0d", exp_word.out_z, rsp_data.out_z);
               if (rsp_data.out_w !== exp_word.out_w)
                  $error("out_w: expected %0d, got %0d", exp_word.out_w, rsp_data.out_w);
               if (rsp_data.w_zero !== exp_word.w_zero)
                  $error("w_zero: expected %0b, got %0b", exp_word.w_zero, rsp_data.w_zero);
               if (rsp_data.saturated !== exp_word.saturated)
                  $error("saturated: expected %0b, got %0b", exp_word.saturated,
                         rsp_data.saturated);
               if (rsp_data !== exp_word)
                  failures <= failures + 1;
            end
         end
      end
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import vtv_pkg::*;

   localparam int  LATENCY     = 39;
   localparam int  CYCLE_LIMIT = 200000;
   localparam int  PHASES      = 6;
   localparam int  PHASE_WORDS = 190;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   req_type                    req_data;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                         pending;
   int                         failures;
   int                         cycles;
   int                         idle_pct;

   vertex_transform_viewport DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   vertex_transform_viewport_checker scoreboard (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .pending(pending),
      .failures(failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cycles <= 0;
      end else begin
         cycles <= cycles + 1;
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // leaves csr_we high; caller lowers it after the last write
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic send_vertex(logic kind, int x, int y, int z, int w);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_data.kind  <= kind;
      req_data.pos_x <= x;
      req_data.pos_y <= y;
      req_data.pos_z <= z;
      req_data.pos_w <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_entry();
      case ($urandom_range(4))
         0: return 16'($urandom);
         1: return 16'($urandom_range(1024) - 512);
         2: return 16'h0000;
         3: return 16'h0100;
         default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      endcase
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(5))
         0, 1: return $urandom;
         2, 3: return int'($urandom_range(524288)) - 262144;
         4: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         default: return $urandom_range(1) ? 0 : 65536;
      endcase
   endfunction

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      logic [63:0] row_val;
      int          w;
      clock     = 1'b0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = REG_ROW0;
      csr_wdata = '0;
      idle_pct  = 9;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // identity matrix, 640x480 viewport
      send_vertex(1'b0, 65536, 131072, 196608, 65536);
      send_vertex(1'b1, 0, 0, 0, 65536);
      send_vertex(1'b1, -65536, 65536, 0, 65536);
      send_vertex(1'b1, 65536, -65536, 32768, 65536);
      send_vertex(1'b1, 65536, 65536, 65536, 0);               // zero w
      send_vertex(1'b0, 65536, 65536, 65536, 0);
      send_vertex(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_vertex(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_vertex(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);  // overflow
      send_vertex(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -1);
      send_vertex(1'b1, 131072, -131072, 65536, -65536);       // negative w
      send_vertex(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_vertex(1'b1, 0, 0, 0, 32'sh7FFF_FFFF);
      send_vertex(1'b0, -1, -1, -1, -1);
      send_vertex(1'b1, 32768, 32768, 32768, 65536);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++)
               case (phase)
                  0: row_val[16*k +: 16] = 16'h8000;
                  1: row_val[16*k +: 16] = 16'h7FFF;
                  default: row_val[16*k +: 16] = rand_entry();
               endcase
            // about half the time keep a sane w row so screen mode gives usable values
            if (phase > 1 && r == 3 && $urandom_range(1))
               row_val = ROW3_RESET;
            write_reg(REG_ROW0 + CSR_INDEX_WIDTH'(r), row_val);
         end
         case (phase)
            0: begin
               write_reg(REG_WIDTH, 64'd1);
               write_reg(REG_HEIGHT, 64'd1);
            end
            1: begin
               write_reg(REG_WIDTH, 64'd4096);
               write_reg(REG_HEIGHT, 64'd4096);
            end
            2: begin
               write_reg(REG_WIDTH, 64'd0);
               write_reg(REG_HEIGHT, 64'h1FFF);
            end
            default: begin
               write_reg(REG_WIDTH, {$urandom, $urandom});
               write_reg(REG_HEIGHT, 64'($urandom_range(4096, 1)));
            end
         endcase
         csr_we <= 1'b0;
         @(posedge clock);

         idle_pct = (phase < 2) ? 9 : (phase < 4) ? 51 : 0;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            w = ($urandom_range(9) == 0) ? 0 : rand_coord();
            send_vertex(1'($urandom), rand_coord(), rand_coord(), rand_coord(), w);
         end
         wait_drained();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
